// ===== rtl/fdob_pkg.sv =====
package fdob_pkg;

   // Default source frame size.
   localparam int unsigned SRC_WIDTH_DEF  = 160;
   localparam int unsigned SRC_HEIGHT_DEF = 144;

   // Item function codes.
   localparam logic FUNC_WRITE  = 1'b0;
   localparam logic FUNC_RENDER = 1'b1;

   // Box average and LED patch constants.
   localparam logic [15:0] AVG_MASK = 16'hE79C;
   localparam logic [15:0] LED_RED  = 16'hF800;
   localparam logic [7:0]  LED_ROW_LO = 8'd35;
   localparam logic [7:0]  LED_ROW_HI = 8'd45;
   // Display columns below this one map left of source column -8.
   localparam logic [6:0]  LED_COL_LIMIT = 7'd4;
   // Display column that maps to source column zero.
   localparam logic [6:0]  COL_ORIGIN = 7'd8;

   // Per-item position checks carried along with the bank read.
   typedef struct packed {
      logic led;
      logic col_ok;
      logic col1_ok;
      logic row0_ok;
      logic row1_ok;
      logic sy_odd;
   } tap_flags_type;

endpackage

// ===== rtl/frame_downscale_overlay_blend_unit.sv =====
// A render item passes the bank read with stage 1, then stage 2, then the output register.
// Throughput: one item per cycle while the output is not stalled; four frame banks
// split by row and column parity deliver the whole 2x2 block in one synchronous read,
// and a write item uses one bank port. Write items give no result. Stalls are absorbed
// stage by stage, so input is taken while a result waits. Reset clears only the stage
// valid bits; the frame store holds no reset value and needs no clearing pass.
module frame_downscale_overlay_blend_unit #(
   parameter int unsigned SRC_WIDTH  = fdob_pkg::SRC_WIDTH_DEF,
   parameter int unsigned SRC_HEIGHT = fdob_pkg::SRC_HEIGHT_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic        req_func,
   input  logic [7:0]  req_src_col,
   input  logic [7:0]  req_src_row,
   input  logic [15:0] req_src_pixel,
   input  logic [6:0]  req_out_col,
   input  logic [5:0]  req_out_row,
   input  logic [31:0] req_overlay_word,
   input  logic        req_overlay_on,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_pixel_out,
   output logic [6:0]  rsp_res_col,
   output logic [5:0]  rsp_res_row
);

   localparam int unsigned HALF_W     = (SRC_WIDTH + 1) / 2;
   localparam int unsigned HALF_H     = (SRC_HEIGHT + 1) / 2;
   localparam int unsigned BANK_DEPTH = HALF_W * HALF_H;
   localparam int unsigned ADDR_W     = $clog2(BANK_DEPTH);
   localparam logic [10:0] WIDTH_L    = 11'(SRC_WIDTH);
   localparam logic [10:0] HEIGHT_L   = 11'(SRC_HEIGHT);

   // Handshake and stage control.
   logic rsp_load, s2_free, s1_free, accept, wr_en, rd_en;
   logic s1_valid_ff, s1_valid_in;
   logic s2_valid_ff, s2_valid_in;
   logic rsp_valid_ff, rsp_valid_in;

   assign rsp_load  = !rsp_valid_ff || rsp_ready;
   assign s2_free   = !s2_valid_ff || rsp_load;
   assign s1_free   = !s1_valid_ff || s2_free;
   assign req_ready = s1_free;
   assign accept    = req_valid && req_ready;
   assign rd_en     = accept && (req_func == fdob_pkg::FUNC_RENDER);

   assign s1_valid_in  = rd_en ? 1'b1 : (s2_free ? 1'b0 : s1_valid_ff);
   assign s2_valid_in  = s2_free ? s1_valid_ff : s2_valid_ff;
   assign rsp_valid_in = rsp_load ? s2_valid_ff : rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s2_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         s2_valid_ff  <= s2_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Write path: bank chosen by row and column parity.
   logic [1:0]        wr_bank;
   logic [ADDR_W-1:0] wr_addr;
   logic              wr_in_frame;

   assign wr_in_frame = ({3'd0, req_src_col} < WIDTH_L) && ({3'd0, req_src_row} < HEIGHT_L);
   assign wr_en       = accept && (req_func == fdob_pkg::FUNC_WRITE) && wr_in_frame;
   assign wr_bank     = {req_src_row[0], req_src_col[0]};
   assign wr_addr     = ADDR_W'(ADDR_W'(req_src_row[7:1]) * ADDR_W'(HALF_W)
                        + ADDR_W'(req_src_col[7:1]));

   // Render address: sx = 2*(ox-8) is always even, so the block's two columns sit in
   // the even and odd column banks at the same column index.
   logic [6:0]  col2;
   logic [6:0]  n_rows;
   logic [3:0]  hc;
   logic [7:0]  sy;
   logic [7:0]  even_idx;
   logic [6:0]  odd_idx;
   logic [8:0]  sy_inc;
   logic [10:0] sx_ext;
   fdob_pkg::tap_flags_type flags;
   logic [ADDR_W-1:0] rd_addr [4];

   assign col2   = req_out_col - fdob_pkg::COL_ORIGIN;
   // Rows r in 0..oy with ((r+1) & 14) == 0 are those with (r+1) mod 16 of 0 or 1.
   assign n_rows = {1'b0, req_out_row} + 7'd1;
   assign hc     = {n_rows[6:4], 1'b0} + {3'd0, (n_rows[3:0] != 4'd0)};
   assign sy     = {1'b0, req_out_row, 1'b0} + {4'd0, hc} + 8'd2;
   assign sy_inc = {1'b0, sy} + 9'd1;
   // The even row of the pair is at (sy+1)/2 in its bank, the odd row at sy/2.
   assign even_idx = sy_inc[8:1];
   assign odd_idx  = sy[7:1];
   assign sx_ext   = {3'd0, col2, 1'b0};

   assign flags.led     = (req_out_col < fdob_pkg::LED_COL_LIMIT)
                          && (sy > fdob_pkg::LED_ROW_LO) && (sy < fdob_pkg::LED_ROW_HI);
   assign flags.col_ok  = (req_out_col >= fdob_pkg::COL_ORIGIN) && (sx_ext < WIDTH_L);
   assign flags.col1_ok = (req_out_col >= fdob_pkg::COL_ORIGIN)
                          && ((sx_ext + 11'd1) < WIDTH_L);
   assign flags.row0_ok = {3'd0, sy} < HEIGHT_L;
   assign flags.row1_ok = {2'd0, sy_inc} < HEIGHT_L;
   assign flags.sy_odd  = sy[0];

   assign rd_addr[0] = ADDR_W'(ADDR_W'(even_idx) * ADDR_W'(HALF_W) + ADDR_W'(col2));
   assign rd_addr[1] = rd_addr[0];
   assign rd_addr[2] = ADDR_W'(ADDR_W'(odd_idx) * ADDR_W'(HALF_W) + ADDR_W'(col2));
   assign rd_addr[3] = rd_addr[2];

   // Four frame banks: bank index is {row parity, column parity}.
   logic [15:0] rd_data [4];

   for (genvar b = 0; b < 4; b++) begin : g_bank
      logic [15:0] mem [BANK_DEPTH];
      logic [15:0] q_ff;

      always_ff @(posedge clock) begin
         if (wr_en && (wr_bank == 2'(b))) begin
            mem[wr_addr] <= req_src_pixel;
         end
         if (rd_en) begin
            q_ff <= mem[rd_addr[b]];
         end
      end

      assign rd_data[b] = q_ff;
   end

   // Stage 1 payload, loaded with the bank read.
   fdob_pkg::tap_flags_type s1_flags_ff;
   logic [31:0] s1_ov_ff;
   logic        s1_on_ff;
   logic [6:0]  s1_col_ff;
   logic [5:0]  s1_row_ff;

   always_ff @(posedge clock) begin
      if (rd_en) begin
         s1_flags_ff <= flags;
         s1_ov_ff    <= req_overlay_word;
         s1_on_ff    <= req_overlay_on;
         s1_col_ff   <= req_out_col;
         s1_row_ff   <= req_out_row;
      end
   end

   // Box average of the 2x2 block; pixels outside the frame count as zero.
   logic [15:0] p00, p01, p10, p11;
   logic [13:0] q00, q01, q10, q11;
   logic [15:0] box_sum;
   logic [15:0] color;

   always_comb begin
      if (s1_flags_ff.sy_odd) begin
         p00 = rd_data[2];
         p01 = rd_data[3];
         p10 = rd_data[0];
         p11 = rd_data[1];
      end else begin
         p00 = rd_data[0];
         p01 = rd_data[1];
         p10 = rd_data[2];
         p11 = rd_data[3];
      end
      q00 = (s1_flags_ff.col_ok && s1_flags_ff.row0_ok)
            ? 14'((p00 & fdob_pkg::AVG_MASK) >> 2) : 14'd0;
      q01 = (s1_flags_ff.col1_ok && s1_flags_ff.row0_ok)
            ? 14'((p01 & fdob_pkg::AVG_MASK) >> 2) : 14'd0;
      q10 = (s1_flags_ff.col_ok && s1_flags_ff.row1_ok)
            ? 14'((p10 & fdob_pkg::AVG_MASK) >> 2) : 14'd0;
      q11 = (s1_flags_ff.col1_ok && s1_flags_ff.row1_ok)
            ? 14'((p11 & fdob_pkg::AVG_MASK) >> 2) : 14'd0;
      box_sum = {2'd0, q00} + {2'd0, q01} + {2'd0, q10} + {2'd0, q11};
      // The LED patch wins over the column test.
      if (s1_flags_ff.led) begin
         color = fdob_pkg::LED_RED;
      end else if (s1_flags_ff.col_ok) begin
         color = box_sum;
      end else begin
         color = 16'd0;
      end
   end

   // Stage 2 payload.
   logic [15:0] s2_color_ff;
   logic [31:0] s2_ov_ff;
   logic        s2_on_ff;
   logic [6:0]  s2_col_ff;
   logic [5:0]  s2_row_ff;

   always_ff @(posedge clock) begin
      if (s2_free && s1_valid_ff) begin
         s2_color_ff <= color;
         s2_ov_ff    <= s1_ov_ff;
         s2_on_ff    <= s1_on_ff;
         s2_col_ff   <= s1_col_ff;
         s2_row_ff   <= s1_row_ff;
      end
   end

   // Overlay blend; the two weights always sum to 256, so each channel fits 16 bits.
   logic [7:0]  bg_r, bg_g, bg_b;
   logic [7:0]  wt_ov, wt_bg;
   logic [15:0] mix_r, mix_g, mix_b;
   logic [15:0] blended, pixel;

   assign bg_r  = {s2_color_ff[15:11], 3'd0};
   assign bg_g  = {s2_color_ff[10:5], 2'd0};
   assign bg_b  = {s2_color_ff[4:0], 3'd0};
   assign wt_ov = {1'b1, s2_ov_ff[31:25]};
   assign wt_bg = 8'd128 - {1'b0, s2_ov_ff[31:25]};
   assign mix_r = 16'({8'd0, bg_r} * {8'd0, wt_bg}) + 16'({8'd0, s2_ov_ff[7:0]} * {8'd0, wt_ov});
   assign mix_g = 16'({8'd0, bg_g} * {8'd0, wt_bg}) + 16'({8'd0, s2_ov_ff[15:8]} * {8'd0, wt_ov});
   assign mix_b = 16'({8'd0, bg_b} * {8'd0, wt_bg})
                  + 16'({8'd0, s2_ov_ff[23:16]} * {8'd0, wt_ov});
   assign blended = {mix_r[15:11], mix_g[15:10], mix_b[15:11]};
   assign pixel   = s2_on_ff ? blended : s2_color_ff;

   // Output register.
   logic [15:0] rsp_pixel_ff;
   logic [6:0]  rsp_col_ff;
   logic [5:0]  rsp_row_ff;

   always_ff @(posedge clock) begin
      if (rsp_load && s2_valid_ff) begin
         rsp_pixel_ff <= {pixel[7:0], pixel[15:8]};
         rsp_col_ff   <= s2_col_ff;
         rsp_row_ff   <= s2_row_ff;
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_pixel_out = rsp_pixel_ff;
   assign rsp_res_col   = rsp_col_ff;
   assign rsp_res_row   = rsp_row_ff;

endmodule

// ===== rtl/fdob_checker.sv =====
module fdob_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        req_func,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [15:0] rsp_pixel_out,
   input logic [6:0]  rsp_res_col,
   input logic [5:0]  rsp_res_row
);

   // A waiting result stays offered.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result item withdrawn before it was taken");

   // A waiting result keeps its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_pixel_out) && $stable(rsp_res_col)
                                  && $stable(rsp_res_row))
      else $error("result item changed while stalled");

   // With no result waiting, the input side is never blocked.
   assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> req_ready)
      else $error("input stalled with an empty output register");

   // A render item reaches the output through stage 1, stage 2 and the output register when the output drains.
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_func == fdob_pkg::FUNC_RENDER))
         ##1 rsp_ready ##1 rsp_ready |=> rsp_valid)
      else $error("render item missing at the output");

   // Reset empties the output.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result offered right after reset");

endmodule

bind frame_downscale_overlay_blend_unit fdob_checker u_fdob_checker (.*);
